### hdl/magnetometer_self_test_calibrator_unit_macros.svh
// Assertion macros for the magnetometer self-test calibrator.
// Included by the top level; no other dependencies.
`ifndef MAGNETOMETER_SELF_TEST_CALIBRATOR_UNIT_MACROS_SVH
`define MAGNETOMETER_SELF_TEST_CALIBRATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSTC_ASSERT_IMP(lbl, ante, cons)
`define MSTC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/mstc_pkg.sv
// Package for the magnetometer self-test calibrator: widths, codes, gain table.
// No dependencies.
package mstc_pkg;
    localparam int SampleBitsDefault = 16;
    localparam int TotalBitsDefault  = 34;
    localparam int ScaleW = 20;
    localparam int NumW   = 40;
    localparam logic [ScaleW-1:0] ScaleMax = 20'hFFFFF;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_POS   = 2'd1,
        ACT_NEG   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_SAT = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_GAIN = 3'd0,
        CFG_COUNT = 3'd1,
        CFG_LOW = 3'd2,
        CFG_HIGH = 3'd3,
        CFG_XB = 3'd4,
        CFG_YB = 3'd5,
        CFG_ZB = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic clear;
    } lane_ctl_t;

    function automatic logic [10:0] gain_cpmg(input logic [2:0] idx);
        logic [10:0] c;
        begin
            case (idx)
                3'd0: c = 11'd1620;
                3'd1: c = 11'd1300;
                3'd2: c = 11'd970;
                3'd3: c = 11'd780;
                3'd4: c = 11'd530;
                3'd5: c = 11'd460;
                3'd6: c = 11'd390;
                3'd7: c = 11'd280;
                default: c = 11'd0;
            endcase
            return c;
        end
    endfunction
endpackage

### hdl/mstc_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on mstc_pkg.
interface mstc_in_if
    import mstc_pkg::*;
#(
    parameter int SW = 16
);
    logic valid;
    logic ready;
    logic [1:0] action;
    logic signed [SW-1:0] sample_x;
    logic signed [SW-1:0] sample_y;
    logic signed [SW-1:0] sample_z;
    modport source (output valid, action, sample_x, sample_y, sample_z, input ready);
    modport sink (input valid, action, sample_x, sample_y, sample_z, output ready);
endinterface

interface mstc_out_if
    import mstc_pkg::*;
();
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [ScaleW-1:0] x_scale;
    logic [ScaleW-1:0] y_scale;
    logic [ScaleW-1:0] z_scale;
    modport source (output valid, status, x_scale, y_scale, z_scale, input ready);
    modport sink (input valid, status, x_scale, y_scale, z_scale, output ready);
endinterface

### hdl/mstc_lane.sv
// One axis lane: wrapping total, signed truncating divide by n, then
// restoring divide of the numerator by the quotient. Depends on mstc_pkg.
module mstc_lane
    import mstc_pkg::*;
#(
    parameter int TB = TotalBitsDefault
)(
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  logic acc_en,
    input  logic signed [TB-1:0] delta,
    input  lane_ctl_t ctl,
    input  logic [15:0] n,
    input  logic [NumW-1:0] num,
    output logic signed [TB-1:0] total,
    output logic [ScaleW-1:0] scale,
    output logic done
);
    localparam int CW = $clog2(NumW + 1);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV1 = 4'b0010,
        S_DIV2 = 4'b0100,
        S_DONE = 4'b1000
    } lst_t;

    lst_t st_reg, st_next;
    logic signed [TB-1:0] total_reg;
    logic [TB-1:0] quo_reg, quo_next, mag;
    logic [TB:0] rem_reg, rem_next, rtry;
    logic neg_reg;
    logic [NumW-1:0] q2_reg, q2_next;
    logic [NumW:0] r2_reg, r2_next, r2try;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TB-1:0] divq;

    assign total = total_reg;
    assign mag = total_reg[TB-1] ? (~total_reg + 1'b1) : total_reg;
    assign divq = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign done = (st_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            st_reg <= S_IDLE;
        end
        else
        begin
            if (clear)
                total_reg <= '0;
            else if (acc_en)
                total_reg <= total_reg + delta;
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        q2_reg <= q2_next;
        r2_reg <= r2_next;
        cnt_reg <= cnt_next;
        if (ctl.start)
            neg_reg <= total_reg[TB-1];
    end

    always_comb
    begin
        st_next = st_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        q2_next = q2_reg;
        r2_next = r2_reg;
        cnt_next = cnt_reg;
        rtry = {rem_reg[TB-1:0], quo_reg[TB-1]} - {{(TB-15){1'b0}}, n};
        r2try = {r2_reg[NumW-1:0], q2_reg[NumW-1]} - {{(NumW+1-TB){1'b0}}, divq};
        case (st_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    st_next = S_DIV1;
                    quo_next = mag;
                    rem_next = '0;
                    cnt_next = CW'(TB);
                end
            end
            S_DIV1:
            begin
                if (!rtry[TB])
                begin
                    rem_next = rtry;
                    quo_next = {quo_reg[TB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[TB-1:0], quo_reg[TB-1]};
                    quo_next = {quo_reg[TB-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    st_next = S_DIV2;
                    q2_next = num;
                    r2_next = '0;
                    cnt_next = CW'(NumW);
                end
            end
            S_DIV2:
            begin
                if (!r2try[NumW])
                begin
                    r2_next = r2try;
                    q2_next = {q2_reg[NumW-2:0], 1'b1};
                end
                else
                begin
                    r2_next = {r2_reg[NumW-1:0], q2_reg[NumW-1]};
                    q2_next = {q2_reg[NumW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    st_next = S_DONE;
            end
            S_DONE:
            begin
                if (ctl.clear)
                    st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (neg_reg || quo_reg == '0 || q2_reg > NumW'(ScaleMax))
            scale = ScaleMax;
        else
            scale = q2_reg[ScaleW-1:0];
    end
endmodule

### hdl/magnetometer_self_test_calibrator_unit.sv
// Top level of the magnetometer self-test calibrator: config registers,
// three axis lanes and the merging stage. Depends on mstc_pkg, mstc_if, mstc_lane.
//
//   channel  | dir | contents
//   in_ch    | in  | action, sample_x, sample_y, sample_z
//   out_ch   | out | status, x_scale, y_scale, z_scale
//   config   | in  | cfg_we, cfg_index, cfg_data
// Start and sample items are taken back to back while idle. A finish item holds
// the input until its result is taken: the lane division by the sample count
// and the scale division run bit-serially.
// No item is accepted while a finish is in progress or its result waits.
// Reset clears the totals, the saturation flag and loads register defaults.
`include "magnetometer_self_test_calibrator_unit_macros.svh"
module magnetometer_self_test_calibrator_unit
    import mstc_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDefault,
    parameter int TOTAL_BITS = TotalBitsDefault
)(
    input logic clk,
    input logic rst_n,
    mstc_in_if.sink in_ch,
    mstc_out_if.source out_ch,
    input logic cfg_we,
    input logic [2:0] cfg_index,
    input logic [15:0] cfg_data
);
    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_RUN = 4'b0010,
        T_MERGE = 4'b0100,
        T_OUT = 4'b1000
    } tst_t;

    localparam int TB = TOTAL_BITS;
    localparam int LW = ((TB > 31) ? TB : 31) + 2;
    tst_t st_reg, st_next;
    logic [2:0] gain_reg;
    logic [15:0] count_reg, low_reg, high_reg, xb_reg, yb_reg, zb_reg;
    logic sat_reg;
    logic [1:0] status_reg;
    logic [ScaleW-1:0] xs_reg, ys_reg, zs_reg;
    logic signed [LW-1:0] lo_reg, hi_reg;
    logic acc_en, clear, negate, sample_sat, in_go;
    logic signed [TB-1:0] dx, dy, dz, tx, ty, tz;
    logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
    logic [10:0] c;
    logic [NumW-1:0] nx, ny, nz;
    logic [ScaleW-1:0] scx, scy, scz;
    logic [2:0] dn;
    lane_ctl_t ctl;
    logic [1:0] st_calc;
    logic inwin;

    assign in_go = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (st_reg == T_IDLE);
    assign sx = in_ch.sample_x[SAMPLE_BITS-1:0];
    assign sy = in_ch.sample_y[SAMPLE_BITS-1:0];
    assign sz = in_ch.sample_z[SAMPLE_BITS-1:0];
    assign negate = (in_ch.action == ACT_NEG);
    assign dx = negate ? -TB'(sx) : TB'(sx);
    assign dy = negate ? -TB'(sy) : TB'(sy);
    assign dz = negate ? -TB'(sz) : TB'(sz);
    assign acc_en = in_go && !sat_reg &&
        (in_ch.action == ACT_POS || in_ch.action == ACT_NEG);
    assign clear = in_go && in_ch.action == ACT_START;
    assign sample_sat = TB'(sx) <= -TB'(4096) || TB'(sy) <= -TB'(4096) ||
        TB'(sz) <= -TB'(4096);
    assign c = gain_cpmg(gain_reg);
    assign nx = NumW'({c, 3'b0}) * NumW'(xb_reg);
    assign ny = NumW'({c, 3'b0}) * NumW'(yb_reg);
    assign nz = NumW'({c, 3'b0}) * NumW'(zb_reg);
    assign ctl.start = in_go && in_ch.action == ACT_FINISH;
    assign ctl.clear = (st_reg == T_MERGE);

    mstc_lane #(.TB(TB)) u_lx (.clk, .rst_n, .clear, .acc_en, .delta(dx), .ctl,
        .n(count_reg), .num(nx), .total(tx), .scale(scx), .done(dn[0]));
    mstc_lane #(.TB(TB)) u_ly (.clk, .rst_n, .clear, .acc_en, .delta(dy), .ctl,
        .n(count_reg), .num(ny), .total(ty), .scale(scy), .done(dn[1]));
    mstc_lane #(.TB(TB)) u_lz (.clk, .rst_n, .clear, .acc_en, .delta(dz), .ctl,
        .n(count_reg), .num(nz), .total(tz), .scale(scz), .done(dn[2]));

    assign inwin = lo_reg <= LW'(tx) && LW'(tx) <= hi_reg &&
        lo_reg <= LW'(ty) && LW'(ty) <= hi_reg &&
        lo_reg <= LW'(tz) && LW'(tz) <= hi_reg;

    always_comb
    begin
        if (count_reg == '0)
            st_calc = ST_BAD;
        else if (sat_reg)
            st_calc = ST_SAT;
        else if (!inwin)
            st_calc = ST_RANGE;
        else
            st_calc = ST_OK;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            T_IDLE: if (ctl.start) st_next = T_RUN;
            T_RUN: if (dn[0]) st_next = T_MERGE;
            T_MERGE: st_next = T_OUT;
            T_OUT: if (out_ch.ready) st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= T_IDLE;
            sat_reg <= 1'b0;
            gain_reg <= 3'd1;
            count_reg <= 16'd1;
            low_reg <= 16'd10210;
            high_reg <= 16'd24158;
            xb_reg <= 16'd19005;
            yb_reg <= 16'd19005;
            zb_reg <= 16'd17695;
        end
        else
        begin
            st_reg <= st_next;
            if (clear)
                sat_reg <= 1'b0;
            else if (acc_en && sample_sat)
                sat_reg <= 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN: gain_reg <= cfg_data[2:0];
                    CFG_COUNT: count_reg <= cfg_data;
                    CFG_LOW: low_reg <= cfg_data;
                    CFG_HIGH: high_reg <= cfg_data;
                    CFG_XB: xb_reg <= cfg_data;
                    CFG_YB: yb_reg <= cfg_data;
                    CFG_ZB: zb_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Window limits are formed in two registered steps during the lane divisions.
    logic [27:0] lc_reg, hc_reg;
    logic [44:0] lw, hw;
    assign lw = 45'(lc_reg) * 45'(count_reg);
    assign hw = 45'(hc_reg) * 45'(count_reg);
    always_ff @(posedge clk)
    begin
        lc_reg <= 28'(low_reg) * 28'(c);
        hc_reg <= 28'(high_reg) * 28'(c);
        lo_reg <= LW'({1'b0, lw[44:13]});
        hi_reg <= LW'({1'b0, hw[44:13]});
        if (st_reg == T_MERGE)
        begin
            status_reg <= st_calc;
            xs_reg <= (st_calc == ST_OK) ? scx : '0;
            ys_reg <= (st_calc == ST_OK) ? scy : '0;
            zs_reg <= (st_calc == ST_OK) ? scz : '0;
        end
    end

    assign out_ch.valid = (st_reg == T_OUT);
    assign out_ch.status = status_reg;
    assign out_ch.x_scale = xs_reg;
    assign out_ch.y_scale = ys_reg;
    assign out_ch.z_scale = zs_reg;

    `MSTC_ASSERT_IMP(a_lanes_sync, dn[0], dn[1] && dn[2])
    `MSTC_ASSERT_IMP(a_no_in_busy, st_reg != T_IDLE, !in_ch.ready)
    `MSTC_ASSERT_NEXT(a_finish_runs, ctl.start, st_reg == T_RUN)
endmodule

### dv/tb_magnetometer_self_test_calibrator_unit.sv
// Self-checking testbench for the magnetometer self-test calibrator unit.
// Predicts each finish result from the accepted sample items and compares it
// field by field. Depends on mstc_pkg, mstc_if and the top level RTL.
module tb_magnetometer_self_test_calibrator_unit;
    import mstc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] action;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
    } sample_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [19:0] xs;
        logic [19:0] ys;
        logic [19:0] zs;
    } cal_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    mstc_in_if #(.SW(16)) in_ch ();
    mstc_out_if out_ch ();

    magnetometer_self_test_calibrator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sample_item_t pending_items[$];
    cal_result_t expected_cal[$];

    logic [2:0] gain_sel;
    logic [15:0] count_n;
    logic [15:0] lo_ratio;
    logic [15:0] hi_ratio;
    logic [15:0] field_x;
    logic [15:0] field_y;
    logic [15:0] field_z;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic signed [33:0] sum_z;
    logic sat_flag;

    int mismatches = 0;
    int cycles = 0;
    int hold_off = 0;
    bit sender_pause = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_phase = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [10:0] counts_per_mg(input logic [2:0] g);
        logic [10:0] c;
        case (g)
            3'd0: c = 11'd1620;
            3'd1: c = 11'd1300;
            3'd2: c = 11'd970;
            3'd3: c = 11'd780;
            3'd4: c = 11'd530;
            3'd5: c = 11'd460;
            3'd6: c = 11'd390;
            default: c = 11'd280;
        endcase
        return c;
    endfunction

    function automatic logic [19:0] axis_factor(input longint num, input longint total,
                                                input longint n);
        longint q;
        longint r;
        q = total / n;
        if (q <= 0)
            return ScaleMax;
        r = num / q;
        return (r > 64'sd1048575) ? ScaleMax : r[19:0];
    endfunction

    task automatic apply_item(input sample_item_t it);
        longint c;
        longint n;
        longint lo;
        longint hi;
        longint tx;
        longint ty;
        longint tz;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] d;
        cal_result_t r;
        a = it.sx;
        b = it.sy;
        d = it.sz;
        case (action_t'(it.action))
            ACT_START:
            begin
                sum_x = '0;
                sum_y = '0;
                sum_z = '0;
                sat_flag = 1'b0;
            end
            ACT_POS, ACT_NEG:
            begin
                if (!sat_flag)
                begin
                    if (action_t'(it.action) == ACT_POS)
                    begin
                        sum_x = sum_x + 34'(a);
                        sum_y = sum_y + 34'(b);
                        sum_z = sum_z + 34'(d);
                    end
                    else
                    begin
                        sum_x = sum_x - 34'(a);
                        sum_y = sum_y - 34'(b);
                        sum_z = sum_z - 34'(d);
                    end
                    if (a <= -4096 || b <= -4096 || d <= -4096)
                        sat_flag = 1'b1;
                end
            end
            default:
            begin
                c = counts_per_mg(gain_sel);
                n = count_n;
                tx = sum_x;
                ty = sum_y;
                tz = sum_z;
                lo = (longint'(lo_ratio) * c * 2 * n) >>> 14;
                hi = (longint'(hi_ratio) * c * 2 * n) >>> 14;
                r = '0;
                if (n == 0)
                    r.status = ST_BAD;
                else if (sat_flag)
                    r.status = ST_SAT;
                else if (!(lo <= tx && tx <= hi && lo <= ty && ty <= hi
                           && lo <= tz && tz <= hi))
                    r.status = ST_RANGE;
                else
                begin
                    r.status = ST_OK;
                    r.xs = axis_factor(c * field_x * 8, tx, n);
                    r.ys = axis_factor(c * field_y * 8, ty, n);
                    r.zs = axis_factor(c * field_z * 8, tz, n);
                end
                expected_cal.push_back(r);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Driver: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.action <= '0;
            in_ch.sample_x <= '0;
            in_ch.sample_y <= '0;
            in_ch.sample_z <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                apply_item(pending_items.pop_front());
            if ((in_ch.valid && !in_ch.ready)) begin
            end
            else if (sender_pause || pending_items.size() == 0 || gap_left > 0)
            begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_ch.valid <= 1'b1;
                in_ch.action <= pending_items[0].action;
                in_ch.sample_x <= pending_items[0].sx;
                in_ch.sample_y <= pending_items[0].sy;
                in_ch.sample_z <= pending_items[0].sz;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver stalls on its own pattern, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_phase < 8)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_cal.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result status=%0d", out_ch.status);
            end
            else
            begin
                if (out_ch.status !== expected_cal[0].status
                    || out_ch.x_scale !== expected_cal[0].xs
                    || out_ch.y_scale !== expected_cal[0].ys
                    || out_ch.z_scale !== expected_cal[0].zs)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 expected_cal[0].status, expected_cal[0].xs,
                                 expected_cal[0].ys, expected_cal[0].zs,
                                 out_ch.status, out_ch.x_scale, out_ch.y_scale,
                                 out_ch.z_scale);
                end
                void'(expected_cal.pop_front());
            end
        end
    end

    task automatic add_item(input action_t act, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
        sample_item_t it;
        it.action = act;
        it.sx = x;
        it.sy = y;
        it.sz = z;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_cal.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic put_config(input cfg_idx_t idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN: gain_sel = v[2:0];
            CFG_COUNT: count_n = v;
            CFG_LOW: lo_ratio = v;
            CFG_HIGH: hi_ratio = v;
            CFG_XB: field_x = v;
            CFG_YB: field_y = v;
            default: field_z = v;
        endcase
        @(posedge clk);
    endtask

    // One well-formed session: a start, n positive, n negative samples, then finish.
    task automatic add_session(input int n, input int bias, input bit noisy);
        int k;
        int m;
        logic [15:0] v[3];
        add_item(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom));
        for (k = 0; k < 2 * n; k++)
        begin
            for (m = 0; m < 3; m++)
            begin
                v[m] = 16'(bias + $signed($urandom_range(0, 200)) - 100);
                if (k >= n)
                    v[m] = -v[m];
                if (noisy && $urandom_range(0, 9) == 0)
                    v[m] = 16'($urandom);
            end
            add_item((k < n) ? ACT_POS : ACT_NEG, v[0], v[1], v[2]);
        end
        add_item(ACT_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int i;
        int ph;
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gain_sel = 3'd1;
        count_n = 16'd1;
        lo_ratio = 16'd10210;
        hi_ratio = 16'd24158;
        field_x = 16'd19005;
        field_y = 16'd19005;
        field_z = 16'd17695;
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        sat_flag = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, saturation, repeated finish, zero quotient.
        add_session(1, 1100, 1'b0);
        add_item(ACT_FINISH, 16'd0, 16'd0, 16'd0);
        add_item(ACT_START, 16'd0, 16'd0, 16'd0);
        add_item(ACT_POS, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_item(ACT_NEG, 16'h8000, 16'h8000, 16'h8000);
        add_item(ACT_FINISH, 16'd0, 16'd0, 16'd0);
        add_item(ACT_START, 16'd0, 16'd0, 16'd0);
        add_item(ACT_POS, 16'hF000, 16'd5, 16'd5);
        add_item(ACT_POS, 16'd100, 16'd100, 16'd100);
        add_item(ACT_FINISH, 16'd0, 16'd0, 16'd0);
        add_item(ACT_START, 16'd0, 16'd0, 16'd0);
        add_item(ACT_POS, 16'hF001, 16'hF001, 16'hF001);
        add_item(ACT_FINISH, 16'd0, 16'd0, 16'd0);
        add_item(ACT_START, 16'd0, 16'd0, 16'd0);
        add_item(ACT_FINISH, 16'd0, 16'd0, 16'd0);
        wait_drained();

        put_config(CFG_COUNT, 16'd0);
        add_session(1, 1000, 1'b0);
        wait_drained();
        put_config(CFG_COUNT, 16'd1);
        put_config(CFG_LOW, 16'd0);
        put_config(CFG_HIGH, 16'hFFFF);
        put_config(CFG_XB, 16'hFFFF);
        put_config(CFG_YB, 16'd0);
        put_config(CFG_ZB, 16'd1);
        put_config(CFG_GAIN, 16'd0);
        add_session(1, 1, 1'b0);
        add_session(1, 3000, 1'b0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items.
        hold_off = 400;
        for (i = 0; i < 4; i++)
            add_session(2, 800, 1'b0);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            put_config(CFG_GAIN, 16'(ph));
            put_config(CFG_COUNT, 16'($urandom_range(1, 4)));
            put_config(CFG_LOW, (ph == 7) ? 16'hFFFF : 16'($urandom_range(0, 16000)));
            put_config(CFG_HIGH, (ph == 6) ? 16'd0 : 16'($urandom_range(16000, 65535)));
            put_config(CFG_XB, 16'($urandom));
            put_config(CFG_YB, 16'($urandom));
            put_config(CFG_ZB, 16'($urandom));
            for (i = 0; i < 23; i++)
            begin
                n = (count_n != 0 && $urandom_range(0, 3) != 0) ? count_n
                                                                  : $urandom_range(1, 4);
                case ($urandom_range(0, 5))
                    0: add_item(action_t'($urandom_range(0, 3)), 16'($urandom),
                                16'($urandom), 16'($urandom));
                    1: add_session(n, $urandom_range(0, 4000), 1'b1);
                    default: add_session(n, ($urandom_range(50, 1000) * counts_per_mg(gain_sel)
                                             * 2) / 1000, 1'b0);
                endcase
            end
            if (ph == 3)
            begin
                sender_pause = 1;
                while (in_ch.valid)
                    @(posedge clk);
                while (expected_cal.size() != 0)
                    @(posedge clk);
                sender_pause = 0;
            end
            wait_drained();
        end

        wait_drained();
        if (mismatches == 0 && expected_cal.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
